FILE: sv/sha256_pkg.sv
// SHA-256 constants and round helper functions.
// Used by sha256_stream_hasher; no dependencies.
`default_nettype none
package sha256_pkg;

  typedef logic [31:0] word_t;

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam word_t INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;

  function automatic word_t rotr(word_t x, int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t sig0(word_t x);
    sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t sig1(word_t x);
    sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t bsig0(word_t x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t bsig1(word_t x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage
`default_nettype wire

FILE: sv/sha256_stream_hasher.sv
// Byte-stream SHA-256: one byte per beat, eight digest word beats per message.
// A byte beat that fills no block is only stored; a full block adds the rounds
// and a fold, run by the single shared round unit.
// An end beat writes pad bytes one per cycle up to byte 63, then the rounds and
// a fold per pad block (one or two), then 8 digest beats, each held until taken.
// Async active-low reset restores the initial hash; the buffer has no reset.
// Depends on sha256_pkg.
`default_nettype none
module sha256_stream_hasher
  import sha256_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        has_byte_i,
  input  wire logic        end_message_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      digest_word_o,
  output logic [2:0]       word_index_o,
  output logic             last_word_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_PAD, S_ROUND, S_FOLD, S_EMIT
  } state_e;

  state_e      state_q;
  logic [5:0]  cnt_q;        // buffered byte count / pad write pointer
  logic [63:0] bits_q;
  logic        closing_q;    // an end beat is being served
  logic        final_q;      // the block in flight is the length block
  logic [5:0]  rnd_q;
  logic [2:0]  widx_q;
  logic        out_valid_q;
  word_t       h_q [8];
  word_t       v_q [8];
  word_t       w_q [16];
  logic [31:0] buf_q [16];   // block buffer, packed big-endian per word

  word_t t1, t2, wn, wcur;
  logic  in_fire;

  assign in_fire = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);

  // schedule: first 16 rounds read the buffer, then the window recurrence
  assign wn = w_q[0] + sig0(w_q[1]) + w_q[9] + sig1(w_q[14]);
  assign wcur = (rnd_q < 6'd16) ? buf_q[rnd_q[3:0]] : wn;
  assign t1 = v_q[7] + bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
            + ROUND_K[rnd_q] + wcur;
  assign t2 = bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

  assign out_valid_o = out_valid_q;
  assign digest_word_o = h_q[widx_q];
  assign word_index_o = widx_q;
  assign last_word_o = (widx_q == 3'd7);

  // buffer byte write, one byte per cycle
  logic       bw_en;
  logic [5:0] bw_addr;
  logic [7:0] bw_data;

  always_comb begin
    bw_en = 1'b0;
    bw_addr = cnt_q;
    bw_data = data_byte_i;
    if (state_q == S_IDLE && in_fire && has_byte_i) begin
      bw_en = 1'b1;
    end else if (state_q == S_PAD) begin
      bw_en = 1'b1;
      if (closing_q && cnt_q >= 6'd56 && final_q) begin
        bw_data = bits_q[8'd63 - {2'b0, cnt_q[2:0], 3'b0} -: 8];
      end else begin
        bw_data = 8'h00;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (bw_en) begin
      unique case (bw_addr[1:0])
        2'd0: buf_q[bw_addr[5:2]][31:24] <= bw_data;
        2'd1: buf_q[bw_addr[5:2]][23:16] <= bw_data;
        2'd2: buf_q[bw_addr[5:2]][15:8]  <= bw_data;
        default: buf_q[bw_addr[5:2]][7:0] <= bw_data;
      endcase
    end
    // pad marker after the (optional) byte, unless that byte closed a block
    if (state_q == S_IDLE && in_fire && end_message_i &&
        !(has_byte_i && cnt_q == 6'd63)) begin
      logic [5:0] p;
      p = has_byte_i ? cnt_q + 6'd1 : cnt_q;
      unique case (p[1:0])
        2'd0: buf_q[p[5:2]][31:24] <= PAD_BYTE;
        2'd1: buf_q[p[5:2]][23:16] <= PAD_BYTE;
        2'd2: buf_q[p[5:2]][15:8]  <= PAD_BYTE;
        default: buf_q[p[5:2]][7:0] <= PAD_BYTE;
      endcase
    end
    // end beat that filled a block: marker opens the next block once the
    // rounds are done reading byte 0
    if (state_q == S_FOLD && closing_q && !final_q && cnt_q == 6'd1) begin
      buf_q[0][31:24] <= PAD_BYTE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0;
      bits_q <= '0;
      closing_q <= 1'b0;
      final_q <= 1'b0;
      rnd_q <= '0;
      widx_q <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 8; i++) h_q[i] <= INIT_HASH[i];
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            logic [6:0] n;
            n = {1'b0, cnt_q} + (has_byte_i ? 7'd1 : 7'd0);
            if (has_byte_i) bits_q <= bits_q + 64'd8;
            closing_q <= end_message_i;
            final_q <= 1'b0;
            rnd_q <= '0;
            for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
            if (n[6]) begin
              // full block; any end marker lands at byte 0 of the next one
              cnt_q <= end_message_i ? 6'd1 : 6'd0;
              state_q <= S_ROUND;
            end else if (end_message_i) begin
              cnt_q <= n[5:0] + 6'd1;
              final_q <= (n[5:0] < 6'd56);
              state_q <= (n[5:0] == 6'd63) ? S_ROUND : S_PAD;
            end else begin
              cnt_q <= n[5:0];
            end
          end
        end
        S_PAD: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd63) begin
            rnd_q <= '0;
            for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
            state_q <= S_ROUND;
          end
        end
        S_ROUND: begin
          for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
          w_q[15] <= wcur;
          v_q[0] <= t1 + t2;
          v_q[1] <= v_q[0];
          v_q[2] <= v_q[1];
          v_q[3] <= v_q[2];
          v_q[4] <= v_q[3] + t1;
          v_q[5] <= v_q[4];
          v_q[6] <= v_q[5];
          v_q[7] <= v_q[6];
          rnd_q <= rnd_q + 6'd1;
          if (rnd_q == 6'd63) state_q <= S_FOLD;
        end
        S_FOLD: begin
          for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
          rnd_q <= '0;
          if (!closing_q) begin
            state_q <= S_IDLE;
          end else if (final_q) begin
            widx_q <= '0;
            out_valid_q <= 1'b1;
            state_q <= S_EMIT;
          end else begin
            // next block: zeros then length; cnt_q already past the marker
            final_q <= 1'b1;
            state_q <= S_PAD;
          end
        end
        S_EMIT: begin
          if (out_ready_i) begin
            widx_q <= widx_q + 3'd1;
            if (widx_q == 3'd7) begin
              out_valid_q <= 1'b0;
              for (int i = 0; i < 8; i++) h_q[i] <= INIT_HASH[i];
              cnt_q <= '0;
              bits_q <= '0;
              closing_q <= 1'b0;
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !in_ready_o) else $error("ready while busy");
  a_emit_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (state_q == S_EMIT)) else $error("valid outside emit");
  a_round_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROUND && rnd_q == 6'd63) |=> (state_q == S_FOLD))
    else $error("round count");
  a_last_leaves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_word_o) |=> (state_q == S_IDLE))
    else $error("emit end");

endmodule
`default_nettype wire
